// ----- src/sfc_pkg.sv -----
// shared constants and types for the space filling curve coordinate block
// no dependencies; imported by every sfc module and the top level
`timescale 1ns / 1ps
`default_nettype none

package sfc_pkg;

    localparam int MODE_W        = 2;
    localparam int IDX_W         = 10;
    localparam int OUT_W         = 5;
    localparam int DEF_GRID_SIDE = 32;

    // visit order codes
    localparam logic [MODE_W-1:0] MODE_HILBERT     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SNAKE       = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SPIRAL      = 2'd2;
    localparam logic [MODE_W-1:0] MODE_HILBERT_ALT = 2'd3;

    // one cell coordinate as delivered on the result beat
    typedef struct packed {
        logic [OUT_W-1:0] x;
        logic [OUT_W-1:0] y;
    } cell_t;

endpackage : sfc_pkg

`default_nettype wire

// ----- src/sfc_hilbert.sv -----
// hilbert curve index to cell coordinate, one quadrant level per bit pair
// depends on sfc_pkg
`timescale 1ns / 1ps
`default_nettype none

module sfc_hilbert #(
    parameter int GRID_SIDE = sfc_pkg::DEF_GRID_SIDE
) (
    input  wire logic [sfc_pkg::IDX_W-1:0] idx,
    output sfc_pkg::cell_t                 coord
);
    import sfc_pkg::*;

    localparam int CW = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;

    logic [CW-1:0]    hx;
    logic [CW-1:0]    hy;
    logic [CW-1:0]    tmp;
    logic [CW-1:0]    s;
    logic [IDX_W-1:0] t;
    logic             rx;
    logic             ry;

    always_comb
    begin
        hx  = '0;
        hy  = '0;
        tmp = '0;
        s   = '0;
        t   = '0;
        rx  = 1'b0;
        ry  = 1'b0;
        for (int i = 0; i < CW; i++)
        begin
            t  = idx >> (2 * i);
            rx = t[1];
            ry = t[0] ^ rx;
            s  = CW'(1) << i;
            if (!ry)
            begin
                // mirror the lower quadrant when the pair selects the last one
                if (rx)
                begin
                    hx = s - CW'(1) - hx;
                    hy = s - CW'(1) - hy;
                end
                tmp = hx;
                hx  = hy;
                hy  = tmp;
            end
            if (rx)
                hx = hx | s;
            if (ry)
                hy = hy | s;
        end
    end

    logic [CW+OUT_W-1:0] hx_ext;
    logic [CW+OUT_W-1:0] hy_ext;

    assign hx_ext  = (CW+OUT_W)'(hx);
    assign hy_ext  = (CW+OUT_W)'(hy);
    assign coord.x = hx_ext[OUT_W-1:0];
    assign coord.y = hy_ext[OUT_W-1:0];

endmodule : sfc_hilbert

`default_nettype wire

// ----- src/sfc_snake.sv -----
// boustrophedon row snake: row major order with odd rows reversed
// depends on sfc_pkg
`timescale 1ns / 1ps
`default_nettype none

module sfc_snake #(
    parameter int GRID_SIDE = sfc_pkg::DEF_GRID_SIDE
) (
    input  wire logic [sfc_pkg::IDX_W-1:0] idx,
    output sfc_pkg::cell_t                 coord
);
    import sfc_pkg::*;

    localparam int CW = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;

    logic [CW-1:0]       col;
    logic [CW-1:0]       row;
    logic [CW-1:0]       sx;
    logic [CW+OUT_W-1:0] sx_ext;
    logic [CW+OUT_W-1:0] sy_ext;

    // grid side is a power of two: divide is a shift, remainder a mask
    assign col = CW'(idx);
    assign row = CW'(idx >> CW);
    assign sx  = row[0] ? ~col : col;

    assign sx_ext  = (CW+OUT_W)'(sx);
    assign sy_ext  = (CW+OUT_W)'(row);
    assign coord.x = sx_ext[OUT_W-1:0];
    assign coord.y = sy_ext[OUT_W-1:0];

endmodule : sfc_snake

`default_nettype wire

// ----- src/sfc_spiral.sv -----
// inward clockwise spiral: ring found against constant ring starts, then
// the offset is placed along top, right, bottom and left sides
// depends on sfc_pkg
`timescale 1ns / 1ps
`default_nettype none

module sfc_spiral #(
    parameter int GRID_SIDE = sfc_pkg::DEF_GRID_SIDE
) (
    input  wire logic [sfc_pkg::IDX_W-1:0] idx,
    output sfc_pkg::cell_t                 coord
);
    import sfc_pkg::*;

    localparam int CW     = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
    localparam int RINGS  = (GRID_SIDE + 1) / 2;
    // rings starting beyond the largest index can never be hit
    localparam int RING_N = (RINGS > 256) ? 256 : RINGS;
    localparam int RW     = (RING_N > 1) ? $clog2(RING_N) : 1;
    localparam int PW     = (CW + 3 > IDX_W) ? CW + 3 : IDX_W;

    function automatic int ring_start(input int r);
        return 4 * r * (GRID_SIDE - r);
    endfunction

    logic [RING_N-1:0] ge;
    logic [RING_N-1:0] hit;
    logic [RW-1:0]     ring;
    logic [PW-1:0]     start;

    always_comb
    begin
        for (int r = 0; r < RING_N; r++)
            ge[r] = (32'(idx) >= 32'(ring_start(r)));
        for (int r = 0; r < RING_N; r++)
            hit[r] = ge[r] & ((r == RING_N - 1) ? 1'b1 : !ge[(r + 1) % RING_N]);
        ring  = '0;
        start = '0;
        for (int r = 0; r < RING_N; r++)
        begin
            if (hit[r])
            begin
                ring  = ring | RW'(r);
                start = start | PW'(ring_start(r));
            end
        end
    end

    logic [PW-1:0] lo;
    logic [PW-1:0] hi;
    logic [PW-1:0] len;
    logic [PW-1:0] ofs;
    logic [PW-1:0] px;
    logic [PW-1:0] py;

    assign lo  = PW'(ring);
    assign hi  = PW'(GRID_SIDE - 1) - lo;
    assign len = PW'(GRID_SIDE) - (lo << 1);
    assign ofs = PW'(idx) - start;

    always_comb
    begin
        if (ofs < len)
        begin
            px = lo + ofs;
            py = lo;
        end
        else if (ofs < (len << 1) - PW'(1))
        begin
            px = hi;
            py = lo + PW'(1) + (ofs - len);
        end
        else if (ofs < (len << 1) + len - PW'(2))
        begin
            px = hi - PW'(1) - (ofs - ((len << 1) - PW'(1)));
            py = hi;
        end
        else
        begin
            px = lo;
            py = hi - PW'(1) - (ofs - ((len << 1) + len - PW'(2)));
        end
    end

    assign coord.x = px[OUT_W-1:0];
    assign coord.y = py[OUT_W-1:0];

endmodule : sfc_spiral

`default_nettype wire

// ----- src/space_filling_curve_coord.sv -----
// top level of the space filling curve coordinate block: input stage,
// three coordinate units and the result register
// depends on sfc_pkg, sfc_hilbert, sfc_snake, sfc_spiral
`timescale 1ns / 1ps
`default_nettype none

// Turns a visit index on a GRID_SIDE x GRID_SIDE grid (GRID_SIDE a power of
// two, 2 to 1024) into the column and row of the cell visited at that index.
// The order is picked per beat by mode: 0 or 3 hilbert curve, 1 row snake with
// odd rows reversed, 2 inward clockwise spiral starting at the top left. The
// index is taken modulo the number of cells, and cell_x / cell_y carry the low
// five bits of the coordinate. The block takes one beat every clock while the
// result side does not stall, and holds a two stage pipeline: the input
// register, then one pass through the coordinate units into the result
// register, from which the result beat is offered. A stalled result beat
// holds the result stage; the input stage still takes a beat while it is
// empty. There is no configuration and no state that outlives a beat.
module space_filling_curve_coord #(
    parameter int GRID_SIDE = sfc_pkg::DEF_GRID_SIDE
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [sfc_pkg::MODE_W-1:0]  mode,
    input  wire logic [sfc_pkg::IDX_W-1:0]   visit_index,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [sfc_pkg::OUT_W-1:0]        cell_x,
    output logic [sfc_pkg::OUT_W-1:0]        cell_y
);
    import sfc_pkg::*;

    localparam int CW = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
    // index mask for the modulo by the cell count (a power of four)
    localparam logic [IDX_W-1:0] IDX_MASK =
        (2 * CW >= IDX_W) ? {IDX_W{1'b1}} : IDX_W'((1 << (2 * CW)) - 1);

    // input stage
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [MODE_W-1:0] mode_reg;
    logic [IDX_W-1:0]  index_reg;

    // result stage
    logic              out_valid_reg;
    logic              out_valid_next;
    cell_t             cell_reg;
    cell_t             cell_next;

    logic              s1_adv;
    logic              in_fire;
    logic [IDX_W-1:0]  idx_wrapped;
    cell_t             hil_cell;
    cell_t             snk_cell;
    cell_t             spi_cell;

    // the result stage frees up when it is empty or its beat leaves now
    assign s1_adv   = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_fire  = in_valid && in_ready;

    assign idx_wrapped = index_reg & IDX_MASK;

    sfc_hilbert #(.GRID_SIDE(GRID_SIDE)) u_hilbert (
        .idx   (idx_wrapped),
        .coord (hil_cell)
    );

    sfc_snake #(.GRID_SIDE(GRID_SIDE)) u_snake (
        .idx   (idx_wrapped),
        .coord (snk_cell)
    );

    sfc_spiral #(.GRID_SIDE(GRID_SIDE)) u_spiral (
        .idx   (idx_wrapped),
        .coord (spi_cell)
    );

    // order select; the spare code falls to hilbert
    always_comb
    begin
        case (mode_reg)
            MODE_SNAKE:  cell_next = snk_cell;
            MODE_SPIRAL: cell_next = spi_cell;
            default:     cell_next = hil_cell;
        endcase
    end

    // input stage fills on a taken beat, drains when it moves on
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_adv)
            out_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mode_reg  <= mode;
            index_reg <= visit_index;
        end
        if (s1_adv && s1_valid_reg)
            cell_reg <= cell_next;
    end

    assign out_valid = out_valid_reg;
    assign cell_x    = cell_reg.x;
    assign cell_y    = cell_reg.y;

    // a taken input beat always lands in the input stage
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> s1_valid_reg)
    else $error("input beat lost on entry");

    // a full input stage that advances always produces a result beat
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_adv |=> out_valid_reg)
    else $error("beat lost between input stage and result stage");

    // a full input stage that cannot advance keeps its beat
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(index_reg)
                                   && $stable(mode_reg))
    else $error("input stage overwritten while stalled");

    // coordinates stay on the grid when the grid fits the field
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (GRID_SIDE >= 32)
                          || ((32'(cell_x) < GRID_SIDE) && (32'(cell_y) < GRID_SIDE)))
    else $error("coordinate off the grid");

endmodule : space_filling_curve_coord

`default_nettype wire

// ----- tb/sfc_coord_checker.sv -----
// checker for space_filling_curve_coord: watches both channels, predicts each
// cell coordinate and compares it with the result beats
// depends on sfc_pkg
`timescale 1ns / 1ps

module sfc_coord_checker (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    input  wire logic                       in_ready,
    input  wire logic [sfc_pkg::MODE_W-1:0] mode,
    input  wire logic [sfc_pkg::IDX_W-1:0]  visit_index,
    input  wire logic                       out_valid,
    input  wire logic                       out_ready,
    input  wire logic [sfc_pkg::OUT_W-1:0]  cell_x,
    input  wire logic [sfc_pkg::OUT_W-1:0]  cell_y,
    output int                              error_count,
    output int                              outstanding
);

    import sfc_pkg::*;

    localparam int GRID = DEF_GRID_SIDE;
    localparam int REPORT_MAX = 10;

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [IDX_W-1:0]  index;
        cell_t             coord;
    } visit_t;

    visit_t expected_cells[$];

    // coordinate of the cell visited at index idx under visit order m
    function automatic cell_t cell_for_visit(input logic [MODE_W-1:0] m,
                                             input logic [IDX_W-1:0] idx);
        int d, x, y, t, s, rx, ry, tmp;
        int r, st, ring, start, lo, hi, len, o;
        cell_t c;
        begin
            d = int'(idx) % (GRID * GRID);
            x = 0;
            y = 0;
            case (m)
                MODE_SNAKE:
                begin
                    y = d / GRID;
                    x = d % GRID;
                    if (y % 2 == 1)
                        x = GRID - 1 - x;
                end
                MODE_SPIRAL:
                begin
                    ring = 0;
                    start = 0;
                    // last ring whose start does not exceed the index
                    for (r = 0; r < (GRID + 1) / 2; r++)
                    begin
                        st = 4 * r * (GRID - r);
                        if (st <= d)
                        begin
                            ring = r;
                            start = st;
                        end
                    end
                    lo = ring;
                    hi = GRID - 1 - ring;
                    len = hi - lo + 1;
                    o = d - start;
                    if (o < len)
                    begin
                        x = lo + o;
                        y = lo;
                    end
                    else if (o < 2 * len - 1)
                    begin
                        x = hi;
                        y = lo + 1 + (o - len);
                    end
                    else if (o < 3 * len - 2)
                    begin
                        x = hi - 1 - (o - (2 * len - 1));
                        y = hi;
                    end
                    else
                    begin
                        x = lo;
                        y = hi - 1 - (o - (3 * len - 2));
                    end
                end
                default:
                begin
                    // hilbert, for both hilbert codes
                    t = d;
                    for (s = 1; s < GRID; s = s << 1)
                    begin
                        rx = (t >> 1) & 1;
                        ry = (t ^ rx) & 1;
                        if (ry == 0)
                        begin
                            if (rx == 1)
                            begin
                                x = s - 1 - x;
                                y = s - 1 - y;
                            end
                            tmp = x;
                            x = y;
                            y = tmp;
                        end
                        x = x + s * rx;
                        y = y + s * ry;
                        t = t >> 2;
                    end
                end
            endcase
            c.x = x[OUT_W-1:0];
            c.y = y[OUT_W-1:0];
            return c;
        end
    endfunction

    always @(posedge clk)
    begin
        visit_t head;
        visit_t item;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_cells.size() == 0)
                begin
                    if (error_count < REPORT_MAX)
                        $display("%0t: result beat (%0d,%0d) with nothing expected",
                                 $realtime, cell_x, cell_y);
                    error_count++;
                end
                else
                begin
                    head = expected_cells.pop_front();
                    if (cell_x !== head.coord.x || cell_y !== head.coord.y)
                    begin
                        if (error_count < REPORT_MAX)
                            $display("%0t: mode %0d index %0d expected (%0d,%0d) got (%0d,%0d)",
                                     $realtime, head.mode, head.index,
                                     head.coord.x, head.coord.y, cell_x, cell_y);
                        error_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                item.mode = mode;
                item.index = visit_index;
                item.coord = cell_for_visit(mode, visit_index);
                expected_cells.push_back(item);
            end
            outstanding = expected_cells.size();
        end
    end

endmodule : sfc_coord_checker

// ----- tb/tb_top.sv -----
// top of the space_filling_curve_coord testbench: clock, reset, beat stimulus
// under several idling phases, and the verdict
// depends on sfc_pkg, sfc_coord_checker and the block itself
`timescale 1ns / 1ps

module tb_top;

    import sfc_pkg::*;

    // generous cycle budget for about 520 beats
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_PER_PHASE = 100;
    localparam int HOLD_CYCLES = 60;
    localparam int DRAIN_CYCLES = 8;

    typedef enum int {
        PH_DIRECTED,
        PH_FREE,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH_IDLE,
        PH_PRESSURE
    } phase_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  visit_index;
    logic              out_valid;
    logic              out_ready;
    logic [OUT_W-1:0]  cell_x;
    logic [OUT_W-1:0]  cell_y;

    int     error_count;
    int     outstanding;
    int     cycle_count;
    phase_t phase;
    int     send_idle_pct;
    int     recv_stall_pct;
    bit     hold_done;

    space_filling_curve_coord i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .visit_index (visit_index),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cell_x      (cell_x),
        .cell_y      (cell_y)
    );

    sfc_coord_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .visit_index (visit_index),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cell_x      (cell_x),
        .cell_y      (cell_y),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    // 4 ns clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // free running cycle count for the watchdog
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
        end
    end

    // watchdog: a hung handshake ends the run here
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("FAIL space_filling_curve_coord");
        $finish;
    end

    // offer one input beat, with an optional random gap in front of it;
    // returns right after the edge that takes the beat
    task automatic send_beat(input logic [MODE_W-1:0] m, input logic [IDX_W-1:0] idx);
        begin
            // idle gap, valid low only in the steps where no beat is offered
            while ($urandom_range(0, 99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid    <= 1'b1;
            mode        <= m;
            visit_index <= idx;
            // hold the beat until the block takes it
            do
                @(posedge clk);
            while (!in_ready);
        end
    endtask

    // one random beat: mostly uniform, sometimes at or next to a spiral ring start
    task automatic send_random_beat();
        logic [MODE_W-1:0] m;
        int                idx;
        int                r;
        begin
            m = MODE_W'($urandom_range(0, 3));
            if ($urandom_range(0, 5) == 0)
            begin
                r   = $urandom_range(1, 15);
                idx = 4 * r * (DEF_GRID_SIDE - r) + $urandom_range(0, 2) - 1;
            end
            else
                idx = $urandom_range(0, 1023);
            send_beat(m, IDX_W'(idx));
        end
    endtask

    // receiver: random stalls per phase, plus one long hold-off during the
    // pressure phase while the sender keeps offering beats
    initial
    begin
        out_ready <= 1'b0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (phase == PH_PRESSURE && !hold_done)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
                hold_done = 1'b1;
            end
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // stimulus and verdict
    initial
    begin
        int i;
        phase          = PH_DIRECTED;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        mode        <= MODE_HILBERT;
        visit_index <= '0;

        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, every order, alternating bit patterns
        send_beat(MODE_HILBERT, 10'd0);
        send_beat(MODE_HILBERT, 10'd1023);
        send_beat(MODE_HILBERT, 10'h155);
        send_beat(MODE_HILBERT, 10'h2aa);
        send_beat(MODE_HILBERT, 10'd512);
        // snake: row ends and the turn into a reversed row
        send_beat(MODE_SNAKE, 10'd0);
        send_beat(MODE_SNAKE, 10'd31);
        send_beat(MODE_SNAKE, 10'd32);
        send_beat(MODE_SNAKE, 10'd63);
        send_beat(MODE_SNAKE, 10'd1023);
        // spiral: corners of the outer ring, ring starts, innermost ring
        send_beat(MODE_SPIRAL, 10'd0);
        send_beat(MODE_SPIRAL, 10'd31);
        send_beat(MODE_SPIRAL, 10'd62);
        send_beat(MODE_SPIRAL, 10'd93);
        send_beat(MODE_SPIRAL, 10'd123);
        send_beat(MODE_SPIRAL, 10'd124);
        send_beat(MODE_SPIRAL, 10'd1019);
        send_beat(MODE_SPIRAL, 10'd1020);
        send_beat(MODE_SPIRAL, 10'd1023);
        // mode three must follow the hilbert curve
        send_beat(MODE_HILBERT_ALT, 10'd0);
        send_beat(MODE_HILBERT_ALT, 10'd1023);
        send_beat(MODE_HILBERT_ALT, 10'h155);
        send_beat(MODE_HILBERT_ALT, 10'h2aa);

        // random beats, one idling pattern per phase
        phase = PH_FREE;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (i = 0; i < RANDOM_PER_PHASE; i++)
            send_random_beat();

        phase = PH_SEND_IDLE;
        send_idle_pct  = 65;
        recv_stall_pct = 0;
        for (i = 0; i < RANDOM_PER_PHASE; i++)
            send_random_beat();

        phase = PH_RECV_STALL;
        send_idle_pct  = 0;
        recv_stall_pct = 65;
        for (i = 0; i < RANDOM_PER_PHASE; i++)
            send_random_beat();

        phase = PH_BOTH_IDLE;
        send_idle_pct  = 18;
        recv_stall_pct = 18;
        for (i = 0; i < RANDOM_PER_PHASE; i++)
            send_random_beat();

        // back to back beats against a long receiver hold-off
        phase = PH_PRESSURE;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (i = 0; i < RANDOM_PER_PHASE; i++)
            send_random_beat();

        in_valid <= 1'b0;

        // drain, then a further idle wait to catch stray result beats
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (error_count == 0 && outstanding == 0)
            $display("PASS space_filling_curve_coord");
        else
            $display("FAIL space_filling_curve_coord");
        $finish;
    end

endmodule : tb_top
